// ----- rtl/sle_pkg.sv -----
package sle_pkg;

  localparam int CAPACITY   = 128;
  localparam int DATA_WIDTH = 32;

  // fixed widths of the item fields
  localparam int OP_W    = 2;
  localparam int POS_W   = 8;
  localparam int VALUE_W = 32;

  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  // wide enough to compare a position against count + 1 without wrap
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOCATE = 2'd2,
    OP_GET    = 2'd3
  } op_t;

  typedef struct packed {
    logic load;
    logic idx_init;
    logic idx_step;
    logic wr_move;
    logic wr_place;
    logic cnt_inc;
    logic cnt_dec;
    logic set_ok;
    logic set_found;
    logic set_read;
    logic out_load;
  } sle_cmd_t;

  typedef struct packed {
    op_t  op;
    logic pos_ok;
    logic move_done;
    logic scan_end;
    logic match;
    logic out_free;
  } sle_stat_t;

endpackage

// ----- rtl/sle_ram.sv -----
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sle_ctrl.sv -----
module sle_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sle_pkg::sle_stat_t stat,
  output sle_pkg::sle_cmd_t  cmd
);

  import sle_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MOVE_RD,
    S_MOVE_WR,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_GET_CAP,
    S_FINISH
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        case (stat.op)
          OP_LOCATE: begin
            cmd.idx_init = 1'b1;
            state_next   = S_SCAN_RD;
          end
          OP_GET: begin
            // read of entry pos-1 issued this cycle
            state_next = stat.pos_ok ? S_GET_CAP : S_FINISH;
          end
          default: begin
            if (stat.pos_ok) begin
              cmd.idx_init = 1'b1;
              state_next   = S_MOVE_RD;
            end else begin
              state_next = S_FINISH;
            end
          end
        endcase
      end
      S_MOVE_RD: begin
        if (stat.move_done) begin
          if (stat.op == OP_INSERT) begin
            cmd.wr_place = 1'b1;
            cmd.cnt_inc  = 1'b1;
          end else begin
            cmd.cnt_dec = 1'b1;
          end
          cmd.set_ok = 1'b1;
          state_next = S_FINISH;
        end else begin
          state_next = S_MOVE_WR;
        end
      end
      S_MOVE_WR: begin
        cmd.wr_move  = 1'b1;
        cmd.idx_step = 1'b1;
        state_next   = S_MOVE_RD;
      end
      S_SCAN_RD: begin
        state_next = stat.scan_end ? S_FINISH : S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (stat.match) begin
          cmd.set_found = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.idx_step = 1'b1;
          state_next   = S_SCAN_RD;
        end
      end
      S_GET_CAP: begin
        cmd.set_read = 1'b1;
        state_next   = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/sle_dp.sv -----
module sle_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [sle_pkg::OP_W-1:0]      opcode,
  input  logic [sle_pkg::POS_W-1:0]     position,
  input  logic [sle_pkg::VALUE_W-1:0]   value,
  input  sle_pkg::sle_cmd_t             cmd,
  output sle_pkg::sle_stat_t            stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic [sle_pkg::POS_W-1:0]     found_position,
  output logic [sle_pkg::VALUE_W-1:0]   read_value,
  output logic [sle_pkg::POS_W-1:0]     list_length
);

  import sle_pkg::*;

  op_t                   op_q;
  logic [POS_W-1:0]      pos_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      idx;
  logic                  res_ok;
  logic [POS_W-1:0]      res_found;
  logic [VALUE_W-1:0]    res_read;

  logic [CNT_W-1:0]      idx_m1;
  logic [CNT_W-1:0]      pos_cnt;
  logic [CNT_W-1:0]      pos_m1;
  logic [CMP_W-1:0]      pos_w;
  logic [CMP_W-1:0]      cnt_w;
  logic [CMP_W-1:0]      idx_w;
  logic                  pos_nz;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign idx_m1  = idx - CNT_W'(1);
  assign pos_cnt = CNT_W'(pos_q);
  assign pos_m1  = pos_cnt - CNT_W'(1);
  assign pos_w   = CMP_W'(pos_q);
  assign cnt_w   = CMP_W'(count);
  assign idx_w   = CMP_W'(idx);
  assign pos_nz  = (pos_q != '0);

  // read port: insert pulls from idx-1, delete and locate from idx, get from pos-1
  always_comb begin
    case (op_q)
      OP_INSERT: ram_raddr = idx_m1[ADDR_W-1:0];
      OP_GET:    ram_raddr = pos_m1[ADDR_W-1:0];
      default:   ram_raddr = idx[ADDR_W-1:0];
    endcase
  end

  always_comb begin
    ram_we    = cmd.wr_move | cmd.wr_place;
    ram_wdata = cmd.wr_place ? val_q : ram_rdata;
    if (cmd.wr_place) begin
      ram_waddr = pos_m1[ADDR_W-1:0];
    end else if (op_q == OP_INSERT) begin
      ram_waddr = idx[ADDR_W-1:0];
    end else begin
      ram_waddr = idx_m1[ADDR_W-1:0];
    end
  end

  sle_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat.op = op_q;
    case (op_q)
      OP_INSERT: stat.pos_ok = pos_nz && (pos_w <= cnt_w + CMP_W'(1)) &&
                               (count != CNT_W'(CAPACITY));
      default:   stat.pos_ok = pos_nz && (pos_w <= cnt_w);
    endcase
    // insert walks idx down to pos, delete walks it up to count
    stat.move_done = (op_q == OP_INSERT) ? (idx_w < pos_w) : (idx >= count);
    stat.scan_end  = (idx >= count);
    stat.match     = (ram_rdata == val_q);
    stat.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q      <= op_t'(opcode);
      pos_q     <= position;
      val_q     <= DATA_WIDTH'(value);
      res_ok    <= 1'b0;
      res_found <= '0;
      res_read  <= '0;
    end
    if (cmd.idx_init) begin
      case (op_q)
        OP_INSERT: idx <= count;
        OP_DELETE: idx <= pos_cnt;
        default:   idx <= '0;
      endcase
    end else if (cmd.idx_step) begin
      idx <= (op_q == OP_INSERT) ? idx_m1 : idx + CNT_W'(1);
    end
    if (cmd.set_ok) begin
      res_ok <= 1'b1;
    end
    if (cmd.set_found) begin
      res_ok    <= 1'b1;
      res_found <= POS_W'(idx + CNT_W'(1));
    end
    if (cmd.set_read) begin
      res_ok   <= 1'b1;
      res_read <= VALUE_W'(ram_rdata);
    end
    if (cmd.out_load) begin
      ok             <= res_ok;
      found_position <= res_found;
      read_value     <= res_read;
      list_length    <= POS_W'(count);
    end
  end

endmodule

// ----- rtl/sequential_list_engine_unit.sv -----
// Ordered list of up to CAPACITY words in a single-port-write, registered-read
// RAM. Each accepted word (opcode, one-based position, value) yields exactly one
// result word. Insert and delete move one entry at a time (RAM read, then
// write), at most 127 entries per operation. Locate scans entries from the first
// until it finds the value or reaches the entry count; get reads one entry, and
// a failing insert, delete or get moves no entries. The list is handled one word
// at a time; the next word is taken as soon as the previous result is in the
// output register, even if that result has not yet been taken. No clearing pass
// is needed after reset: the entry count alone marks which entries are valid.
module sequential_list_engine_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sle_pkg::OP_W-1:0]      opcode,
  input  logic [sle_pkg::POS_W-1:0]     position,
  input  logic [sle_pkg::VALUE_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic [sle_pkg::POS_W-1:0]     found_position,
  output logic [sle_pkg::VALUE_W-1:0]   read_value,
  output logic [sle_pkg::POS_W-1:0]     list_length
);

  import sle_pkg::*;

  sle_cmd_t  cmd;
  sle_stat_t stat;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sle_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .opcode         (opcode),
    .position       (position),
    .value          (value),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .ok             (ok),
    .found_position (found_position),
    .read_value     (read_value),
    .list_length    (list_length)
  );

endmodule
